// ===== hw/rtl/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg
// shared types, codes and constants of the segmented indirect reference table
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int CAPACITY_DEF = 4096;

    localparam int ACT_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SERIAL_W = 12;
    localparam int KIND_W   = 2;
    localparam int LIMIT_W  = 13;
    localparam int HALF_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_W  = 104;
    localparam int OUT_W = 104;

    localparam logic [KIND_W-1:0]  KIND_RESET   = 2'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd4096;
    localparam logic [WORD_W-1:0]  MARKER_RESET = 32'hffff_ffff;

    localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SAVE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESTORE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KIND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STALE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_GET,
        S_REMOVE,
        S_POP,
        S_RESTORE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LIMIT_W-1:0] limit;
        logic [WORD_W-1:0]  marker;
    } t_cfg;

endpackage

// ===== hw/rtl/segmented_indirect_reference_table.sv =====
// ----------------------------------------------------------------------------
// segmented_indirect_reference_table
// handle table with per-slot serials, holes and segment cookies
//
//   channel   dir  handshake                 content
//   s_axis    in   i_s_tvalid / o_s_tready   action, cookie, obj_handle, ref_in
//   m_axis    out  o_m_tvalid / i_m_tready   ref_out, obj_out, status, success,
//                                            cookie_out
//   cfg       in   i_cfg_valid / o_cfg_ready register index, write data
//
// get, append add and remove run as a slot memory read, then a check/write
// hole fill scans one slot per cycle from top-1 down; pop walks one per cycle
// restore nulls one slot per cycle from the new top to the old top
// after reset a clearing pass over all CAPACITY slots runs before the first item
// the result register frees the input side as soon as the result is taken
// ----------------------------------------------------------------------------
module segmented_indirect_reference_table #(
    parameter int CAPACITY = sirt_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // action[2:0], cookie[34:3], obj_handle[66:35], ref_in[98:67], zero fill
    input  logic [sirt_pkg::IN_W-1:0]      i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // ref_out[31:0], obj_out[63:32], status[66:64], success[67],
    // cookie_out[99:68], zero fill
    output logic [sirt_pkg::OUT_W-1:0]     o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sirt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sirt_pkg::WORD_W-1:0]    i_cfg_data
);
    import sirt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TW = $clog2(CAPACITY + 1);

    t_cfg r_cfg;

    logic [WORD_W-1:0]   ref_out, obj_out, cookie_out;
    logic [STATUS_W-1:0] status;
    logic                success;

    logic [AW-1:0]       rd_addr, wr_addr;
    logic [WORD_W-1:0]   rd_obj, wr_obj;
    logic [SERIAL_W-1:0] rd_ser, wr_ser;
    logic                wr_obj_en, wr_ser_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind <= KIND_RESET;
            r_cfg.limit <= LIMIT_RESET;
            r_cfg.marker <= MARKER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KIND:   r_cfg.kind <= i_cfg_data[KIND_W-1:0];
                REG_LIMIT:  r_cfg.limit <= i_cfg_data[LIMIT_W-1:0];
                REG_MARKER: r_cfg.marker <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sirt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .TW       (TW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_action     (i_s_tdata[2:0]),
        .i_cookie     (i_s_tdata[34:3]),
        .i_obj_handle (i_s_tdata[66:35]),
        .i_ref_in     (i_s_tdata[98:67]),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_ref_out    (ref_out),
        .o_obj_out    (obj_out),
        .o_status     (status),
        .o_success    (success),
        .o_cookie_out (cookie_out),
        .o_rd_addr    (rd_addr),
        .i_rd_obj     (rd_obj),
        .i_rd_ser     (rd_ser),
        .o_wr_addr    (wr_addr),
        .o_wr_obj_en  (wr_obj_en),
        .o_wr_obj     (wr_obj),
        .o_wr_ser_en  (wr_ser_en),
        .o_wr_ser     (wr_ser)
    );

    sirt_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .o_rd_obj    (rd_obj),
        .o_rd_ser    (rd_ser),
        .i_wr_addr   (wr_addr),
        .i_wr_obj_en (wr_obj_en),
        .i_wr_obj    (wr_obj),
        .i_wr_ser_en (wr_ser_en),
        .i_wr_ser    (wr_ser)
    );

    assign o_m_tdata = {4'b0000, cookie_out, success, status, obj_out, ref_out};

endmodule

// ===== hw/rtl/sirt_store.sv =====
// ----------------------------------------------------------------------------
// sirt_store
// slot memories: object handle and serial, one read and one write port each
// ----------------------------------------------------------------------------
module sirt_store #(
    parameter int CAPACITY = sirt_pkg::CAPACITY_DEF,
    parameter int AW       = 12
) (
    input  logic                          i_clk,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [sirt_pkg::WORD_W-1:0]   o_rd_obj,
    output logic [sirt_pkg::SERIAL_W-1:0] o_rd_ser,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic                          i_wr_obj_en,
    input  logic [sirt_pkg::WORD_W-1:0]   i_wr_obj,
    input  logic                          i_wr_ser_en,
    input  logic [sirt_pkg::SERIAL_W-1:0] i_wr_ser
);
    import sirt_pkg::*;

    logic [WORD_W-1:0]   r_obj_mem [CAPACITY];
    logic [SERIAL_W-1:0] r_ser_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr_obj_en) begin
            r_obj_mem[i_wr_addr] <= i_wr_obj;
        end
        o_rd_obj <= r_obj_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_ser_en) begin
            r_ser_mem[i_wr_addr] <= i_wr_ser;
        end
        o_rd_ser <= r_ser_mem[i_rd_addr];
    end

endmodule

// ===== hw/rtl/sirt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sirt_ctrl
// item sequencer: clearing pass, decode, slot read-modify-write, hole scan, pop, restore walk
// ----------------------------------------------------------------------------
module sirt_ctrl #(
    parameter int CAPACITY = sirt_pkg::CAPACITY_DEF,
    parameter int AW       = 12,
    parameter int TW       = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sirt_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sirt_pkg::ACT_W-1:0]    i_action,
    input  logic [sirt_pkg::WORD_W-1:0]   i_cookie,
    input  logic [sirt_pkg::WORD_W-1:0]   i_obj_handle,
    input  logic [sirt_pkg::WORD_W-1:0]   i_ref_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sirt_pkg::WORD_W-1:0]   o_ref_out,
    output logic [sirt_pkg::WORD_W-1:0]   o_obj_out,
    output logic [sirt_pkg::STATUS_W-1:0] o_status,
    output logic                          o_success,
    output logic [sirt_pkg::WORD_W-1:0]   o_cookie_out,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [sirt_pkg::WORD_W-1:0]   i_rd_obj,
    input  logic [sirt_pkg::SERIAL_W-1:0] i_rd_ser,
    output logic [AW-1:0]                 o_wr_addr,
    output logic                          o_wr_obj_en,
    output logic [sirt_pkg::WORD_W-1:0]   o_wr_obj,
    output logic                          o_wr_ser_en,
    output logic [sirt_pkg::SERIAL_W-1:0] o_wr_ser
);
    import sirt_pkg::*;

    localparam logic [16:0] CAP17 = 17'(CAPACITY);

    t_state r_state, n_state;
    logic [TW-1:0]     r_top, n_top;
    logic [HALF_W-1:0] r_hole, n_hole;
    logic [TW-1:0]     r_ptr, n_ptr;
    logic [TW-1:0]     r_end, n_end;
    logic [WORD_W-1:0] r_cookie, r_obj, r_ref;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_ref, r_out_obj, r_out_cookie;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_success;

    logic                fin;
    logic [WORD_W-1:0]   f_ref, f_obj, f_cookie;
    logic [STATUS_W-1:0] f_status;
    logic                f_success;

    logic              acc;
    logic [16:0]       top17, ptr17, in_bot17, in_idx17, r_bot17, new_top17;
    logic [HALF_W-1:0] in_idx;
    logic              full, add_scan, get_fail, rm_pre_ok, rm_ok, rm_at_top;
    logic              rd_zero, ptr_above_bot, ptr_last_clear, ptr_last_walk;
    logic [SERIAL_W-1:0] ser_next;
    logic [HALF_W-1:0] hole_dec;

    assign o_ready   = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign acc       = i_valid && o_ready;

    assign top17     = 17'(r_top);
    assign ptr17     = 17'(r_ptr);
    assign in_idx    = i_ref_in[17:2];
    assign in_idx17  = 17'(in_idx);
    assign in_bot17  = 17'(i_cookie[15:0]);
    assign r_bot17   = 17'(r_cookie[15:0]);
    assign new_top17 = (in_bot17 < top17) ? in_bot17 : top17;

    assign full      = (top17 >= 17'(i_cfg.limit)) || (top17 >= CAP17);
    assign add_scan  = (r_hole > i_cookie[31:16]) && (top17 > in_bot17);
    assign get_fail  = (i_ref_in == '0) || (i_ref_in[1:0] != i_cfg.kind)
                       || (in_idx17 >= top17);
    assign rm_pre_ok = (i_ref_in[1:0] == i_cfg.kind) && (in_idx17 >= in_bot17)
                       && (in_idx17 < top17);
    assign rd_zero   = (i_rd_obj == '0);
    assign rm_ok     = (i_rd_ser == r_ref[31:20]) && !rd_zero;
    assign rm_at_top = (ptr17 + 17'd1) == top17;
    assign ptr_above_bot  = ptr17 > r_bot17;
    assign ptr_last_clear = ptr17 == (CAP17 - 17'd1);
    assign ptr_last_walk  = (ptr17 + 17'd1) == 17'(r_end);
    assign ser_next  = i_rd_ser + SERIAL_W'(1);
    assign hole_dec  = (r_hole != '0) ? (r_hole - HALF_W'(1)) : r_hole;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (ptr_last_clear) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_action)
                        ACT_ADD: begin
                            if (i_obj_handle == '0) n_state = S_IDLE;
                            else if (add_scan)      n_state = S_SCAN;
                            else if (full)          n_state = S_IDLE;
                            else                    n_state = S_APPEND;
                        end
                        ACT_GET:     n_state = get_fail ? S_IDLE : S_GET;
                        ACT_REMOVE:  n_state = rm_pre_ok ? S_REMOVE : S_IDLE;
                        ACT_RESTORE: n_state = (new_top17 < top17) ? S_RESTORE : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_zero)            n_state = S_IDLE;
                else if (ptr_above_bot) n_state = S_SCAN;
                else if (full)          n_state = S_IDLE;
                else                    n_state = S_APPEND;
            end
            S_APPEND: n_state = S_IDLE;
            S_GET:    n_state = S_IDLE;
            S_REMOVE: begin
                if (rm_ok && rm_at_top && ptr_above_bot) n_state = S_POP;
                else                                     n_state = S_IDLE;
            end
            S_POP: begin
                if (rd_zero && ptr_above_bot) n_state = S_POP;
                else                          n_state = S_IDLE;
            end
            S_RESTORE: begin
                if (ptr_last_walk) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory access and results
    always_comb begin
        n_top = r_top;
        n_hole = r_hole;
        n_ptr = r_ptr;
        n_end = r_end;
        o_rd_addr = r_ptr[AW-1:0];
        o_wr_addr = r_ptr[AW-1:0];
        o_wr_obj_en = 1'b0;
        o_wr_obj = '0;
        o_wr_ser_en = 1'b0;
        o_wr_ser = '0;
        fin = 1'b0;
        f_ref = '0;
        f_obj = '0;
        f_status = ST_OK;
        f_success = 1'b0;
        f_cookie = '0;
        case (r_state)
            S_CLEAR: begin
                o_wr_obj_en = 1'b1;
                o_wr_ser_en = 1'b1;
                n_ptr = r_ptr + TW'(1);
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_action)
                        ACT_ADD: begin
                            if (i_obj_handle == '0) begin
                                fin = 1'b1;
                            end else if (add_scan) begin
                                n_ptr = r_top - TW'(1);
                            end else if (full) begin
                                fin = 1'b1;
                            end else begin
                                n_ptr = r_top;
                            end
                            o_rd_addr = n_ptr[AW-1:0];
                        end
                        ACT_GET: begin
                            n_ptr = in_idx17[TW-1:0];
                            o_rd_addr = n_ptr[AW-1:0];
                            if (get_fail) begin
                                fin = 1'b1;
                                if (i_ref_in == '0)                  f_status = ST_NULL;
                                else if (i_ref_in[1:0] != i_cfg.kind) f_status = ST_KIND;
                                else                                 f_status = ST_STALE;
                            end
                        end
                        ACT_REMOVE: begin
                            n_ptr = in_idx17[TW-1:0];
                            o_rd_addr = n_ptr[AW-1:0];
                            if (!rm_pre_ok) fin = 1'b1;
                        end
                        ACT_SAVE: begin
                            fin = 1'b1;
                            f_cookie = {r_hole, top17[15:0]};
                        end
                        ACT_RESTORE: begin
                            fin = 1'b1;
                            n_hole = i_cookie[31:16];
                            n_ptr = new_top17[TW-1:0];
                            n_top = new_top17[TW-1:0];
                            n_end = r_top;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_zero) begin
                    o_wr_obj_en = 1'b1;
                    o_wr_obj = r_obj;
                    o_wr_ser_en = 1'b1;
                    o_wr_ser = ser_next;
                    n_hole = r_hole - HALF_W'(1);
                    fin = 1'b1;
                    f_ref = {ser_next, 2'b00, ptr17[15:0], i_cfg.kind};
                    f_success = (f_ref != '0);
                end else if (ptr_above_bot) begin
                    n_ptr = r_ptr - TW'(1);
                end else if (full) begin
                    fin = 1'b1;
                end else begin
                    n_ptr = r_top;
                end
                o_rd_addr = n_ptr[AW-1:0];
            end
            S_APPEND: begin
                o_wr_obj_en = 1'b1;
                o_wr_obj = r_obj;
                o_wr_ser_en = 1'b1;
                o_wr_ser = ser_next;
                n_top = r_top + TW'(1);
                fin = 1'b1;
                f_ref = {ser_next, 2'b00, ptr17[15:0], i_cfg.kind};
                f_success = (f_ref != '0);
            end
            S_GET: begin
                fin = 1'b1;
                if (rd_zero)                          f_status = ST_DELETED;
                else if (i_rd_ser != r_ref[31:20])    f_status = ST_STALE;
                else if (i_rd_obj == i_cfg.marker)    f_status = ST_NULL;
                else                                  f_obj = i_rd_obj;
            end
            S_REMOVE: begin
                fin = 1'b1;
                if (rm_ok) begin
                    f_success = 1'b1;
                    o_wr_obj_en = 1'b1;
                    if (rm_at_top) begin
                        n_top = r_ptr;
                        n_hole = hole_dec;
                        n_ptr = r_ptr - TW'(1);
                    end else if (r_hole != {HALF_W{1'b1}}) begin
                        n_hole = r_hole + HALF_W'(1);
                    end
                end
                o_rd_addr = n_ptr[AW-1:0];
            end
            S_POP: begin
                if (rd_zero) begin
                    n_top = r_ptr;
                    n_hole = hole_dec;
                    if (ptr_above_bot) n_ptr = r_ptr - TW'(1);
                end
                o_rd_addr = n_ptr[AW-1:0];
            end
            S_RESTORE: begin
                o_wr_obj_en = 1'b1;
                n_ptr = r_ptr + TW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_top <= '0;
            r_hole <= '0;
            r_ptr <= '0;
            r_end <= '0;
        end else begin
            r_state <= n_state;
            r_top <= n_top;
            r_hole <= n_hole;
            r_ptr <= n_ptr;
            r_end <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cookie <= i_cookie;
            r_obj <= i_obj_handle;
            r_ref <= i_ref_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_ref <= f_ref;
            r_out_obj <= f_obj;
            r_out_status <= f_status;
            r_out_success <= f_success;
            r_out_cookie <= f_cookie;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ref_out    = r_out_ref;
    assign o_obj_out    = r_out_obj;
    assign o_status     = r_out_status;
    assign o_success    = r_out_success;
    assign o_cookie_out = r_out_cookie;

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        top17 <= CAP17)
        else $error("top index beyond capacity");

    a_item_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_out_valid || r_state != S_IDLE))
        else $error("accepted item neither answered nor in progress");

    a_scan_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_POP) |-> (ptr17 < top17 || r_state == S_POP))
        else $error("hole scan pointer at or above top");

    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

endmodule

// ===== tb/tb_segmented_indirect_reference_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segmented_indirect_reference_table
// Self-checking bench for the handle table. A behavioral copy of the table
// predicts each result as items are accepted; a checker compares every
// result field against the oldest prediction. Directed tests cover the
// corner cases, random phases run add/get/remove sequences, also malformed,
// with segment save/restore under several register settings, idling and stalls.
// ----------------------------------------------------------------------------
module tb_segmented_indirect_reference_table;
    import sirt_pkg::*;

    localparam int CAP = 4096;
    localparam int STALL_LIMIT = 30000;

    typedef struct packed {
        logic [WORD_W-1:0]   cookie_out;
        logic                success;
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   obj_out;
        logic [WORD_W-1:0]   ref_out;
    } t_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OUT_W-1:0]     o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    segmented_indirect_reference_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // table copy
    logic [WORD_W-1:0]   tbl_obj [CAP];
    logic [SERIAL_W-1:0] tbl_ser [CAP];
    logic [LIMIT_W-1:0]  tbl_top;
    logic [HALF_W-1:0]   tbl_holes;
    logic [KIND_W-1:0]   cfg_kind;
    logic [LIMIT_W-1:0]  cfg_limit;
    logic [WORD_W-1:0]   cfg_marker;

    t_res        expected_q[$];
    logic [31:0] live_refs[$];
    logic [31:0] seg_stack[$];
    logic [31:0] seg_cookie;
    int          err_cnt;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] table_cookie();
        return {tbl_holes, 3'b000, tbl_top};
    endfunction

    function automatic t_res predict_table(logic [2:0] act, logic [31:0] ck,
                                          logic [31:0] ob, logic [31:0] rf);
        t_res r;
        logic [15:0] bottom;
        logic [15:0] idx;
        logic [12:0] lim;
        logic [12:0] i;
        logic [16:0] new_top;
        bit found;
        r = '0;
        bottom = ck[15:0];
        idx = rf[17:2];
        lim = (cfg_limit > CAP) ? 13'(CAP) : cfg_limit;
        case (act)
            ACT_ADD: begin
                if (ob != 0) begin
                    found = 0;
                    idx = 16'(tbl_top);
                    if (tbl_holes > ck[31:16]) begin
                        i = tbl_top;
                        while (17'(i) > 17'(bottom)) begin
                            i = i - 1;
                            if (tbl_obj[i] == 0) begin
                                idx = 16'(i);
                                found = 1;
                                tbl_holes = tbl_holes - 1;
                                break;
                            end
                        end
                    end
                    if (found || tbl_top < lim) begin
                        if (!found) begin
                            idx = 16'(tbl_top);
                            tbl_top = tbl_top + 1;
                        end
                        tbl_obj[idx] = ob;
                        tbl_ser[idx] = tbl_ser[idx] + 1;
                        r.ref_out = {tbl_ser[idx], 2'b00, idx, cfg_kind};
                        r.success = 1'b1;
                    end
                end
            end
            ACT_GET: begin
                if (rf == 0) r.status = ST_NULL;
                else if (rf[1:0] != cfg_kind) r.status = ST_KIND;
                else if (17'(idx) >= 17'(tbl_top)) r.status = ST_STALE;
                else if (tbl_obj[idx] == 0) r.status = ST_DELETED;
                else if (rf[31:20] != tbl_ser[idx]) r.status = ST_STALE;
                else if (tbl_obj[idx] == cfg_marker) r.status = ST_NULL;
                else begin
                    r.status = ST_OK;
                    r.obj_out = tbl_obj[idx];
                end
            end
            ACT_REMOVE: begin
                if (rf[1:0] == cfg_kind && idx >= bottom && 17'(idx) < 17'(tbl_top)
                        && tbl_ser[idx] == rf[31:20] && tbl_obj[idx] != 0) begin
                    r.success = 1'b1;
                    tbl_obj[idx] = 0;
                    if (17'(idx) == 17'(tbl_top) - 1) begin
                        while (17'(tbl_top) > 17'(bottom) && tbl_obj[tbl_top-1] == 0) begin
                            tbl_top = tbl_top - 1;
                            if (tbl_holes != 0) tbl_holes = tbl_holes - 1;
                        end
                    end else if (tbl_holes != 16'hffff) begin
                        tbl_holes = tbl_holes + 1;
                    end
                end
            end
            ACT_SAVE: r.cookie_out = table_cookie();
            ACT_RESTORE: begin
                new_top = (17'(ck[15:0]) > 17'(tbl_top)) ? 17'(tbl_top) : 17'(ck[15:0]);
                for (int k = int'(new_top); k < int'(tbl_top); k++) tbl_obj[k] = 0;
                tbl_top = 13'(new_top);
                tbl_holes = ck[31:16];
            end
            default: ;
        endcase
        return r;
    endfunction

    // sends one item and returns its predicted result
    task automatic send_item(input logic [2:0] act, input logic [31:0] ck,
                             input logic [31:0] ob, input logic [31:0] rf,
                             output t_res res);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, rf, ob, ck, act};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        res = predict_table(act, ck, ob, rf);
        expected_q.push_back(res);
    endtask

    task automatic send_and_track(input logic [2:0] act, input logic [31:0] ck,
                                  input logic [31:0] ob, input logic [31:0] rf);
        t_res res;
        send_item(act, ck, ob, rf, res);
        if (act == ACT_ADD && res.success) begin
            live_refs.push_back(res.ref_out);
            if (live_refs.size() > 64) void'(live_refs.pop_front());
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_KIND:   cfg_kind = val[1:0];
            REG_LIMIT:  cfg_limit = val[12:0];
            REG_MARKER: cfg_marker = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] kind, input logic [12:0] lim,
                              input logic [31:0] marker);
        drain();
        write_reg(REG_KIND, {30'b0, kind});
        write_reg(REG_LIMIT, {19'b0, lim});
        write_reg(REG_MARKER, marker);
    endtask

    task automatic test_directed();
        t_res a, b, c, d;
        logic [31:0] ck0;
        send_item(ACT_SAVE, 32'hffff_ffff, 0, 0, a);
        ck0 = a.cookie_out;
        send_item(ACT_GET, 0, 0, 0, a);
        send_item(ACT_ADD, ck0, 0, 0, a);
        send_item(ACT_ADD, ck0, 32'h1234_5678, 0, a);
        send_item(ACT_ADD, ck0, 32'hffff_ffff, 0, b);
        send_item(ACT_ADD, ck0, 32'h0000_0001, 0, c);
        send_item(ACT_ADD, ck0, 32'h8000_0000, 0, d);
        send_item(ACT_GET, 0, 0, a.ref_out, a);
        send_item(ACT_GET, 0, 0, b.ref_out, b);
        send_item(ACT_GET, 0, 0, {c.ref_out[31:2], 2'd2}, c);
        send_item(ACT_GET, 0, 0, {12'd1, 2'b0, 16'd100, 2'd1}, c);
        send_item(ACT_GET, 0, 0, {12'd7, 2'b0, 16'd2, 2'd1}, c);
        send_item(ACT_REMOVE, ck0, 0, {12'd1, 2'b0, 16'd1, 2'd1}, c);
        send_item(ACT_GET, 0, 0, {12'd1, 2'b0, 16'd1, 2'd1}, c);
        send_item(ACT_REMOVE, ck0, 0, {12'd1, 2'b0, 16'd1, 2'd1}, c);
        send_item(ACT_ADD, ck0, 32'hcafe_f00d, 0, c);
        send_item(ACT_REMOVE, ck0, 0, d.ref_out, c);
        send_item(ACT_REMOVE, 32'h0000_0003, 0, a.ref_out, c);
        send_item(ACT_SAVE, 0, 0, 0, c);
        send_item(3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, c);
        send_item(3'd7, 0, 0, 0, c);
        // saturate the hole counter, then drop a middle slot
        send_item(ACT_RESTORE, 32'hffff_ffff, 0, 0, c);
        send_item(ACT_REMOVE, 32'hffff_0000, 0, {12'd1, 2'b0, 16'd0, 2'd1}, c);
        send_item(ACT_SAVE, 0, 0, 0, c);
        send_item(ACT_RESTORE, 32'h0000_0000, 0, 0, c);
    endtask

    task automatic test_full_table();
        t_res r;
        set_config(2'd1, 13'd1, 32'hffff_ffff);
        send_item(ACT_ADD, 0, 32'h11, 0, r);
        send_item(ACT_ADD, 0, 32'h22, 0, r);
        send_item(ACT_RESTORE, 0, 0, 0, r);
    endtask

    task automatic test_random(input int n_items);
        logic [31:0] ck, ob, rf;
        int r;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            ck = ($urandom_range(9) == 0) ? $urandom : seg_cookie;
            rf = (live_refs.size() != 0 && $urandom_range(9) != 0)
                 ? live_refs[$urandom_range(live_refs.size() - 1)] : $urandom;
            if ($urandom_range(19) == 0) rf[31:20] = 12'($urandom);
            if ($urandom_range(19) == 0) rf[1:0] = 2'($urandom);
            if (r < 35) begin
                ob = $urandom;
                if ($urandom_range(19) == 0) ob = 0;
                else if ($urandom_range(19) == 0) ob = cfg_marker;
                send_and_track(ACT_ADD, ck, ob, $urandom);
            end else if (r < 60) begin
                send_and_track(ACT_GET, $urandom, $urandom, rf);
            end else if (r < 80) begin
                send_and_track(ACT_REMOVE, ck, $urandom, rf);
            end else if (r < 88) begin
                if (seg_stack.size() < 4) begin
                    seg_cookie = table_cookie();
                    seg_stack.push_back(seg_cookie);
                end
                send_and_track(ACT_SAVE, $urandom, $urandom, $urandom);
            end else if (r < 95) begin
                if (seg_stack.size() != 0) begin
                    ck = seg_stack.pop_back();
                    seg_cookie = (seg_stack.size() != 0) ? seg_stack[$] : 0;
                end else begin
                    ck = {16'($urandom_range(65535)), 16'($urandom_range(80))};
                    if ($urandom_range(3) == 0) ck = $urandom;
                    seg_cookie = 0;
                end
                send_and_track(ACT_RESTORE, ck, $urandom, $urandom);
            end else begin
                send_and_track(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom);
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[$bits(t_res)-1:0];
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", got);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got.ref_out !== want.ref_out) begin
                    $error("ref_out exp %h got %h", want.ref_out, got.ref_out);
                    err_cnt++;
                end
                if (got.obj_out !== want.obj_out) begin
                    $error("obj_out exp %h got %h", want.obj_out, got.obj_out);
                    err_cnt++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    err_cnt++;
                end
                if (got.success !== want.success) begin
                    $error("success exp %0d got %0d", want.success, got.success);
                    err_cnt++;
                end
                if (got.cookie_out !== want.cookie_out) begin
                    $error("cookie_out exp %h got %h", want.cookie_out, got.cookie_out);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < CAP; k++) begin
            tbl_obj[k] = 0;
            tbl_ser[k] = 0;
        end
        tbl_top = 0;
        tbl_holes = 0;
        cfg_kind = KIND_RESET;
        cfg_limit = LIMIT_RESET;
        cfg_marker = MARKER_RESET;
        err_cnt = 0;
        quiet_cycles = 0;
        seg_cookie = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();

        set_config(2'd2, 13'd8191, $urandom);
        test_random(280);

        src_idle_pct = 75;
        set_config(2'd3, 13'd4096, 32'h0000_0001);
        test_random(280);

        src_idle_pct = 0;
        snk_stall_pct = 75;
        set_config(2'd1, 13'd1, 32'hffff_ffff);
        test_random(120);
        set_config(2'd2, 13'd12, $urandom);
        test_random(160);

        src_idle_pct = 27;
        snk_stall_pct = 27;
        set_config(2'd3, 13'd40, 32'hffff_ffff);
        test_random(280);

        drain();
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
